// ===== src/websocket_frame_parser_defines.svh =====
// Assertion helpers for the frame parser.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef WEBSOCKET_FRAME_PARSER_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define WSFP_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSFP_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wsfp_pkg.sv =====
`default_nettype none

package wsfp_pkg;

  // parse phase codes
  localparam logic [2:0] PhFirst   = 3'd0;
  localparam logic [2:0] PhSecond  = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhKey     = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // byte counts of the extended length and key fields
  localparam logic [3:0] ExtLen16Bytes = 4'd2;
  localparam logic [3:0] ExtLen64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes      = 4'd4;

  // result kinds (tuser)
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  // packed result payload: 81 bits, padded to whole bytes
  localparam int unsigned OutFieldW = 81;
  localparam int unsigned OutTdataW = 88;

  typedef struct packed {
    logic        item_kind;
    logic        final_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } wsfp_res_t;

endpackage

`default_nettype wire

// ===== src/websocket_frame_parser.sv =====
// Each taken byte is registered in the input stage, parsed combinationally in wsfp_core,
// and its result registered in the output stage; one byte per cycle unless output stalls.
// The byte that completes a header yields the header result, other header, extended
// length and key bytes yield none; each payload byte yields one.
// Reset (rst_ni low, asynchronous) empties both stages and returns the parser to
// waiting for the first header byte of a frame.
`default_nettype none

`include "websocket_frame_parser_defines.svh"

module websocket_frame_parser
  import wsfp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input byte stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // [7:0] stream_byte
  // parsed results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] final_flag, [3:1] reserved_bits, [7:4] frame_opcode, [8] mask_present,
  // [72:9] payload_length, [80:73] payload_byte, [87:81] zero
  output logic [OutTdataW-1:0]      m_axis_tdata,
  output logic                      m_axis_tlast,  // frame_end
  output logic                      m_axis_tuser   // item_kind: 0 header, 1 payload
);

  // input stage
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // output stage
  logic      out_valid_q, out_valid_d;
  wsfp_res_t out_res_q;

  logic      s_take;
  logic      advance;
  logic      res_valid;
  wsfp_res_t res;

  // assertion terms
  logic      hdr_closes;
  logic      in_stall;
  logic      out_stall;

  // the held byte moves on whenever the output slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? res_valid : (out_valid_q && !m_axis_tready);

  wsfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.item_kind;
  assign m_axis_tlast  = out_res_q.frame_end;
  assign m_axis_tdata  = {{(OutTdataW - OutFieldW){1'b0}},
                          out_res_q.payload_byte,
                          out_res_q.payload_length,
                          out_res_q.mask_present,
                          out_res_q.frame_opcode,
                          out_res_q.reserved_bits,
                          out_res_q.final_flag};

  assign hdr_closes = out_valid_q && (out_res_q.item_kind == KindHeader) && out_res_q.frame_end;
  assign in_stall   = in_valid_q && !advance;
  assign out_stall  = out_valid_q && !m_axis_tready;

  // a header marked as frame end must be an empty frame
  `WSFP_CHECK(a_empty_hdr_len, hdr_closes, out_res_q.payload_length == 64'd0, "bad empty header")

  // a held input byte that cannot move stays put
  `WSFP_CHECK_NEXT(a_in_hold, in_stall, in_valid_q && $stable(in_byte_q), "input byte lost")

  // a stalled result is neither dropped nor overwritten
  `WSFP_CHECK_NEXT(a_out_hold, out_stall, out_valid_q && $stable(out_res_q), "stalled result changed")

endmodule

`default_nettype wire

// ===== src/wsfp_core.sv =====
`default_nettype none

// Frame parse state and one-byte step logic.
module wsfp_core
  import wsfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire logic [7:0] byte_i,
  output logic           res_valid_o,
  output wsfp_res_t      res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic        mask_q, mask_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;

  logic [3:0]  cnt_dec;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;
  logic        len_done;
  logic        hdr_go;

  assign cnt_dec = cnt_q - 4'd1;
  assign rem_dec = rem_q - 64'd1;

  // key bytes in wire order, first byte in the top bits
  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    rem_d   = rem_q;
    key_d   = key_q;
    idx_d   = idx_q;

    len_done    = 1'b0;
    hdr_go      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      case (phase_q)
        PhSecond: begin
          mask_d = byte_i[7];
          key_d  = '0;
          if (byte_i[6:0] == LenCode16 || byte_i[6:0] == LenCode64) begin
            len_d   = '0;
            cnt_d   = (byte_i[6:0] == LenCode16) ? ExtLen16Bytes : ExtLen64Bytes;
            phase_d = PhExtLen;
          end else begin
            len_d    = {57'd0, byte_i[6:0]};
            len_done = 1'b1;
          end
        end
        PhExtLen: begin
          len_d    = {len_q[55:0], byte_i};
          cnt_d    = cnt_dec;
          len_done = (cnt_dec == 4'd0);
        end
        PhKey: begin
          key_d  = {key_q[23:0], byte_i};
          cnt_d  = cnt_dec;
          hdr_go = (cnt_dec == 4'd0);
        end
        PhPayload: begin
          idx_d       = idx_q + 2'd1;
          rem_d       = rem_dec;
          res_valid_o = 1'b1;
          res_o.item_kind    = KindPayload;
          res_o.payload_byte = mask_q ? (byte_i ^ key_byte) : byte_i;
          res_o.frame_end    = (rem_dec == 64'd0);
          if (rem_dec == 64'd0) begin
            phase_d = PhFirst;
          end
        end
        default: begin
          // first header byte; unused phase codes land here too
          hdr_d   = byte_i;
          phase_d = PhSecond;
        end
      endcase

      // length known: fetch the key or finish the header
      if (len_done) begin
        if (mask_d) begin
          cnt_d   = KeyBytes;
          phase_d = PhKey;
        end else begin
          hdr_go = 1'b1;
        end
      end

      if (hdr_go) begin
        res_valid_o        = 1'b1;
        res_o.item_kind    = KindHeader;
        res_o.payload_byte = '0;
        if (len_d == 64'd0) begin
          res_o.frame_end = 1'b1;
          phase_d         = PhFirst;
        end else begin
          res_o.frame_end = 1'b0;
          rem_d           = len_d;
          idx_d           = '0;
          phase_d         = PhPayload;
        end
      end

      res_o.final_flag     = hdr_d[7];
      res_o.reserved_bits  = hdr_d[6:4];
      res_o.frame_opcode   = hdr_d[3:0];
      res_o.mask_present   = mask_d;
      res_o.payload_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      hdr_q   <= '0;
      mask_q  <= 1'b0;
      cnt_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_websocket_frame_parser.sv =====
module tb_websocket_frame_parser;
  import wsfp_pkg::*;

  // One byte of a WebSocket stream is offered per request on the s_axis side;
  // headers, extended lengths and masking keys are parsed by the block, which
  // returns one header result per frame and one unmasked result per payload byte
  // on the m_axis side.
  //
  // Stimulus:
  //   - a short directed table: a zero-length frame, an unmasked one-byte frame
  //     with every reserved bit and opcode 0xF, a masked frame with a
  //     non-minimal 16-bit length, and an unmasked frame with a non-minimal
  //     64-bit length. Rows whose result is obvious carry it typed in; the
  //     others go through the local frame predictor.
  //   - about 1600 bytes of well-formed random frames: random first byte,
  //     random mask flag, 7-bit / 16-bit / 64-bit length encodings, random key
  //     and payload bytes.
  //   - a closing frame whose 64-bit length is all ones (top bit set), which is
  //     never finished; only its first few payload bytes are sent.
  //
  // Flow control:
  //   - both sides drop their valid/ready about 21% of the time at random, except
  //     in a quiet span of the run where both run flat out.
  //   - once, the result side holds off for a long stretch so that the block
  //     backs up and stalls its byte input.
  //   - every so often the byte side waits until all predicted results have come
  //     out before starting a new frame.
  //
  // Inputs change on the falling clock edge; both sides sample on the rising edge.

  localparam int HalfPeriod   = 10;
  localparam int RandomBytes  = 1600;
  localparam int IdlePct      = 21;
  localparam int QuietLo      = 700;   // bytes taken: start of the no-idle span
  localparam int QuietHi      = 1000;  // bytes taken: end of the no-idle span
  localparam int HoldAt       = 300;   // bytes taken when the long result hold starts
  localparam int HoldCycles   = 200;
  localparam int DrainEvery   = 30;    // about one frame in this many waits for drain
  localparam int TailCycles   = 8;     // margin after the last result is accepted
  localparam longint Timeout  = 64'd4_000_000;

  // One stimulus row: a stream byte, optionally with its result typed in.
  typedef struct {
    logic [7:0] b;
    bit         drain;    // wait for all results before offering this byte
    bit         pinned;   // use has_res/res below instead of the predictor
    bit         has_res;
    wsfp_res_t  res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] stream_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [0] final_flag, [3:1] reserved_bits, [7:4] frame_opcode, [8] mask_present,
  // [72:9] payload_length, [80:73] payload_byte, [87:81] zero
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;   // frame_end
  logic                 m_axis_tuser;   // item_kind

  websocket_frame_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor state
  // ---------------------------------------------------------------------------
  logic [2:0]  wire_phase;
  logic [7:0]  first_hdr;    // FIN, RSV1..3, opcode of the current frame
  logic        masked;
  logic [3:0]  field_left;   // bytes still due in the length or key field
  logic [63:0] frame_len;
  logic [63:0] left_to_go;   // payload bytes still due
  logic [31:0] mask_word;    // first key byte on the wire in bits 31:24
  logic [1:0]  key_idx;

  wsfp_res_t   pending_results[$];   // predicted results, oldest first
  stim_row_t   stim[$];
  int          bytes_taken;
  int          mismatches;
  bit          rx_hold;

  wire quiet_span = (bytes_taken >= QuietLo) && (bytes_taken < QuietHi);

  function automatic wsfp_res_t result_of(input logic kind, input logic [7:0] pb,
                                          input logic last);
    wsfp_res_t r;
    r.item_kind      = kind;
    r.final_flag     = first_hdr[7];
    r.reserved_bits  = first_hdr[6:4];
    r.frame_opcode   = first_hdr[3:0];
    r.mask_present   = masked;
    r.payload_length = frame_len;
    r.payload_byte   = pb;
    r.frame_end      = last;
    return r;
  endfunction

  // Header complete: zero-length frames close right here.
  function automatic bit header_out(output wsfp_res_t r);
    if (frame_len == '0) begin
      r = result_of(KindHeader, 8'h00, 1'b1);
      wire_phase = PhFirst;
    end else begin
      r = result_of(KindHeader, 8'h00, 1'b0);
      left_to_go = frame_len;
      key_idx    = '0;
      wire_phase = PhPayload;
    end
    return 1'b1;
  endfunction

  function automatic bit length_done(output wsfp_res_t r);
    r = '0;
    if (masked) begin
      field_left = KeyBytes;
      wire_phase = PhKey;
      return 1'b0;
    end
    return header_out(r);
  endfunction

  // Advance the parse by one stream byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, output wsfp_res_t r);
    logic [7:0] v;
    r = '0;
    case (wire_phase)
      PhSecond: begin
        masked    = b[7];
        mask_word = '0;
        if (b[6:0] < LenCode16) begin
          frame_len = {57'd0, b[6:0]};
          return length_done(r);
        end
        frame_len  = '0;
        field_left = (b[6:0] == LenCode16) ? ExtLen16Bytes : ExtLen64Bytes;
        wire_phase = PhExtLen;
        return 1'b0;
      end
      PhExtLen: begin
        frame_len  = {frame_len[55:0], b};
        field_left = field_left - 4'd1;
        if (field_left == '0) return length_done(r);
        return 1'b0;
      end
      PhKey: begin
        mask_word  = {mask_word[23:0], b};
        field_left = field_left - 4'd1;
        if (field_left == '0) return header_out(r);
        return 1'b0;
      end
      PhPayload: begin
        v = b;
        if (masked) v = b ^ mask_word[8*(3-key_idx) +: 8];
        key_idx    = key_idx + 2'd1;
        left_to_go = left_to_go - 64'd1;
        if (left_to_go == '0) wire_phase = PhFirst;
        r = result_of(KindPayload, v, left_to_go == '0);
        return 1'b1;
      end
      default: begin
        first_hdr  = b;
        wire_phase = PhSecond;
        return 1'b0;
      end
    endcase
  endfunction

  // Typed-in expectation for the directed table.
  function automatic wsfp_res_t mk(input logic k, input logic fin, input logic [2:0] rsv,
                                   input logic [3:0] op, input logic m,
                                   input logic [63:0] len, input logic [7:0] pb,
                                   input logic last);
    return {k, fin, rsv, op, m, len, pb, last};
  endfunction

  task automatic queue_byte(input logic [7:0] b, input bit drain);
    stim_row_t row;
    row.b       = b;
    row.drain   = drain;
    row.pinned  = 1'b0;
    row.has_res = 1'b0;
    row.res     = '0;
    stim = {stim, row};
  endtask

  // A well-formed frame with random content. open_ended sends an all-ones
  // 64-bit length and only a few of its payload bytes.
  task automatic queue_frame(input bit drain, input bit open_ended);
    logic [7:0]  hdr0;
    logic [6:0]  code;
    logic [63:0] len;
    logic [31:0] key;
    logic        m;
    int          n_ext;
    int          pick;
    longint      n_pay;
    hdr0 = 8'($urandom_range(255));
    m    = 1'($urandom_range(1));
    key  = $urandom();
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? 64'($urandom_range(300)) : 64'($urandom_range(12));
    if (open_ended) begin
      code  = LenCode64;
      n_ext = 8;
      len   = '1;
    end else if (pick < 70) begin
      len   = ($urandom_range(3) == 0) ? 64'($urandom_range(125)) : 64'($urandom_range(8));
      code  = len[6:0];
      n_ext = 0;
    end else if (pick < 85) begin
      code  = LenCode16;
      n_ext = 2;
    end else begin
      code  = LenCode64;
      n_ext = 8;
    end
    queue_byte(hdr0, drain);
    queue_byte({m, code}, 1'b0);
    for (int k = n_ext - 1; k >= 0; k--) queue_byte(len[8*k +: 8], 1'b0);
    if (m) for (int k = 3; k >= 0; k--) queue_byte(key[8*k +: 8], 1'b0);
    n_pay = open_ended ? 6 : longint'(len);
    for (longint k = 0; k < n_pay; k++) queue_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic log_mismatch(input string field, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Byte side: builds the stimulus, offers each request, predicts on accept
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed[25];
    wsfp_res_t r;
    bit        has;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    bytes_taken   = 0;
    wire_phase    = PhFirst;
    first_hdr     = '0;
    masked        = 1'b0;
    field_left    = '0;
    frame_len     = '0;
    left_to_go    = '0;
    mask_word     = '0;
    key_idx       = '0;

    directed = '{
      // zero-length ping with FIN: header result closes the frame
      '{8'h89, 0, 1, 0, '0},
      '{8'h00, 0, 1, 1, mk(KindHeader, 1'b1, 3'd0, 4'h9, 1'b0, 64'd0, 8'h00, 1'b1)},
      // no FIN, all reserved bits, opcode 0xF, one unmasked byte passed through
      '{8'h7F, 0, 1, 0, '0},
      '{8'h01, 0, 1, 1, mk(KindHeader, 1'b0, 3'd7, 4'hF, 1'b0, 64'd1, 8'h00, 1'b0)},
      '{8'hAB, 0, 1, 1, mk(KindPayload, 1'b0, 3'd7, 4'hF, 1'b0, 64'd1, 8'hAB, 1'b1)},
      // masked frame, 16-bit length of 1 (non-minimal), key FF 00 55 AA
      '{8'h82, 0, 1, 0, '0},
      '{8'hFE, 0, 1, 0, '0},
      '{8'h00, 0, 1, 0, '0},
      '{8'h01, 0, 1, 0, '0},
      '{8'hFF, 0, 1, 0, '0},
      '{8'h00, 0, 1, 0, '0},
      '{8'h55, 0, 1, 0, '0},
      '{8'hAA, 0, 1, 1, mk(KindHeader, 1'b1, 3'd0, 4'h2, 1'b1, 64'd1, 8'h00, 1'b0)},
      '{8'h3C, 0, 0, 0, '0},
      // unmasked frame, 64-bit length of 1 (non-minimal)
      '{8'h01, 0, 0, 0, '0},
      '{8'h7F, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h00, 0, 0, 0, '0},
      '{8'h01, 0, 0, 0, '0},
      '{8'h5A, 0, 0, 0, '0}
    };
    foreach (directed[i]) stim = {stim, directed[i]};

    // first random frame always waits for the directed results to drain
    queue_frame(1'b1, 1'b0);
    while (stim.size() < 25 + RandomBytes)
      queue_frame($urandom_range(DrainEvery - 1) == 0, 1'b0);
    queue_frame(1'b1, 1'b1);

    @(posedge rst_ni);
    @(negedge clk_i);

    foreach (stim[i]) begin
      if (stim[i].drain) begin
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      while (!quiet_span && $urandom_range(99) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= stim[i].b;
      do @(posedge clk_i); while (!s_axis_tready);

      has = parse_byte(stim[i].b, r);
      if (stim[i].pinned) begin
        has = stim[i].has_res;
        r   = stim[i].res;
      end
      if (has) pending_results = {pending_results, r};
      bytes_taken++;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready, with one long hold to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (quiet_span) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    rx_hold = 1'b0;
    wait (bytes_taken >= HoldAt);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  initial mismatches = 0;

  always @(posedge clk_i) begin
    wsfp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with none pending", 64'(m_axis_tdata), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.item_kind)
          log_mismatch("item_kind", 64'(m_axis_tuser), 64'(want.item_kind));
        if (m_axis_tdata[0] !== want.final_flag)
          log_mismatch("final_flag", 64'(m_axis_tdata[0]), 64'(want.final_flag));
        if (m_axis_tdata[3:1] !== want.reserved_bits)
          log_mismatch("reserved_bits", 64'(m_axis_tdata[3:1]), 64'(want.reserved_bits));
        if (m_axis_tdata[7:4] !== want.frame_opcode)
          log_mismatch("frame_opcode", 64'(m_axis_tdata[7:4]), 64'(want.frame_opcode));
        if (m_axis_tdata[8] !== want.mask_present)
          log_mismatch("mask_present", 64'(m_axis_tdata[8]), 64'(want.mask_present));
        if (m_axis_tdata[72:9] !== want.payload_length)
          log_mismatch("payload_length", m_axis_tdata[72:9], want.payload_length);
        if (m_axis_tdata[80:73] !== want.payload_byte)
          log_mismatch("payload_byte", 64'(m_axis_tdata[80:73]), 64'(want.payload_byte));
        if (m_axis_tlast !== want.frame_end)
          log_mismatch("frame_end", 64'(m_axis_tlast), 64'(want.frame_end));
        if (m_axis_tdata[OutTdataW-1:OutFieldW] !== '0)
          log_mismatch("tdata padding", 64'(m_axis_tdata[OutTdataW-1:OutFieldW]), '0);
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(Timeout);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
